FILE: hdl/packed_component_table_defines.svh
// Assertion macros shared by the packed component table RTL.
// Included by packed_component_table for its concurrent assertions; no other dependencies.
`ifndef PACKED_COMPONENT_TABLE_DEFINES_SVH
`define PACKED_COMPONENT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define PCT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define PCT_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define PCT_ASSERT(label, clk, rst_n, prop, msg)
`define PCT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: hdl/pct_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the packed component table.
// No dependencies; used by the interfaces and by packed_component_table.
package pct_pkg;

  localparam int OP_W     = 2;
  localparam int ENTITY_W = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_GET       = 2'd2,
    OP_REMOVE_IF = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_ERASE,
    S_FETCH,
    S_DONE
  } state_t;

endpackage

FILE: hdl/pct_in_if.sv
`timescale 1ns / 1ps
// Request channel of the packed component table: valid/ready plus one operation.
// Depends on pct_pkg for the field widths.
interface pct_in_if;
  import pct_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ENTITY_W-1:0] entity;
  logic [DATA_W-1:0]   component_value;

  modport source (output valid, output op, output entity, output component_value,
                  input ready);
  modport sink (input valid, input op, input entity, input component_value,
                output ready);
endinterface

FILE: hdl/pct_out_if.sv
`timescale 1ns / 1ps
// Response channel of the packed component table: valid/ready plus one result.
// Depends on pct_pkg for the field widths.
interface pct_out_if;
  import pct_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_value;
  logic [STATUS_W-1:0] status;
  logic                found;

  modport source (output valid, output read_value, output status, output found,
                  input ready);
  modport sink (input valid, input read_value, input status, input found,
                output ready);
endinterface

FILE: hdl/pct_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/packed_component_table.sv
`timescale 1ns / 1ps
// Packed component table: values kept densely packed, keyed by entity number.
// A request passes S_LOOK, then S_ERASE for a successful remove or remove-if, or
// S_FETCH for a successful get (one extra RAM pass), then S_DONE, where the response
// is registered. A new request is taken only in S_IDLE, after that response is loaded.
// After reset every entity RAM address is cleared in S_CLEAR, with in_ch.ready low.
module packed_component_table #(
  parameter int ENTITY_LIMIT = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pct_in_if.sink    in_ch,
  pct_out_if.source out_ch
);
  import pct_pkg::*;

`include "packed_component_table_defines.svh"

  localparam int IW = $clog2(ENTITY_LIMIT);
  localparam int CW = $clog2(ENTITY_LIMIT + 1);
  localparam int EW = IW + 1;
  localparam int SW = IW + VALUE_WIDTH;

  state_t                 state_r, state_nxt;
  logic [IW-1:0]          clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;

  op_t                    op_r;
  logic [IW-1:0]          ent_idx_r;
  logic                   in_range_r;
  logic [VALUE_WIDTH-1:0] val_r;

  logic [DATA_W-1:0]      res_value_r;
  status_t                res_status_r;
  logic                   res_found_r;
  logic [DATA_W-1:0]      out_value_r;
  status_t                out_status_r;
  logic                   out_found_r;

  // Entity RAM word: {present, slot}. Slot RAM word: {owner, value}.
  logic          ent_we;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic          slot_we;
  logic [IW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;

  logic          accept;
  logic          load_out;
  logic          had;
  logic [IW-1:0] hole;
  logic [IW-1:0] mover;
  logic [CW-1:0] count_dec;
  logic [IW-1:0] last_idx;
  logic          full;
  logic          do_insert;
  logic          do_remove;
  status_t       look_status;

  pct_ram #(.WIDTH(EW), .DEPTH(ENTITY_LIMIT)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  pct_ram #(.WIDTH(SW), .DEPTH(ENTITY_LIMIT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign count_dec = count_r - CW'(1);
  assign last_idx  = count_dec[IW-1:0];
  assign full      = (count_r == CW'(ENTITY_LIMIT));
  assign had       = in_range_r && ent_rdata[IW];
  assign hole      = ent_rdata[IW-1:0];
  assign mover     = slot_rdata[SW-1:VALUE_WIDTH];

  // The entity lookup is issued in the transfer cycle; the slot RAM reads the last
  // packed entry at the same time, and the hole later when a get needs its value.
  assign ent_raddr  = IW'(in_ch.entity);
  assign slot_raddr = (state_r == S_LOOK) ? hole : last_idx;

  always_comb begin
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    look_status = ST_OK;
    case (op_r)
      OP_INSERT: begin
        if (had) begin
          look_status = ST_PRESENT;
        end else if (!in_range_r || full) begin
          look_status = ST_FULL;
        end else begin
          do_insert = (state_r == S_LOOK);
        end
      end
      OP_REMOVE: begin
        if (had && (count_r != '0)) begin
          do_remove = (state_r == S_LOOK);
        end else begin
          look_status = ST_ABSENT;
        end
      end
      OP_GET: begin
        if (!had) begin
          look_status = ST_ABSENT;
        end
      end
      OP_REMOVE_IF: begin
        if (had && (count_r != '0)) begin
          do_remove = (state_r == S_LOOK);
        end
      end
      default: begin
        look_status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == IW'(ENTITY_LIMIT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (do_remove) begin
          state_nxt = S_ERASE;
        end else if ((op_r == OP_GET) && had) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ERASE: state_nxt = S_DONE;
      S_FETCH: state_nxt = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM writes and counters. A remove rewrites the mover's map entry first and
  // clears the removed entity in the next cycle, so a remove of the last entry ends
  // with the entity marked absent.
  always_comb begin
    ent_we        = 1'b0;
    ent_waddr     = ent_idx_r;
    ent_wdata     = '0;
    slot_we       = 1'b0;
    slot_waddr    = hole;
    slot_wdata    = slot_rdata;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_CLEAR: begin
        ent_we       = 1'b1;
        ent_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + IW'(1);
      end
      S_LOOK: begin
        if (do_insert) begin
          ent_we     = 1'b1;
          ent_wdata  = {1'b1, count_r[IW-1:0]};
          slot_we    = 1'b1;
          slot_waddr = count_r[IW-1:0];
          slot_wdata = {ent_idx_r, val_r};
          count_nxt  = count_r + CW'(1);
        end else if (do_remove) begin
          ent_we     = 1'b1;
          ent_waddr  = mover;
          ent_wdata  = {1'b1, hole};
          slot_we    = 1'b1;
          count_nxt  = count_dec;
        end
      end
      S_ERASE: begin
        ent_we = 1'b1;
      end
      default: begin
        ent_we = 1'b0;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= op_t'(in_ch.op);
      ent_idx_r  <= IW'(in_ch.entity);
      in_range_r <= (32'(in_ch.entity) < 32'(ENTITY_LIMIT));
      val_r      <= VALUE_WIDTH'(in_ch.component_value);
    end
    if (state_r == S_LOOK) begin
      res_status_r <= look_status;
      res_found_r  <= had;
      res_value_r  <= '0;
    end
    if (state_r == S_FETCH) begin
      res_value_r <= DATA_W'(slot_rdata[VALUE_WIDTH-1:0]);
    end
    if (load_out) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.found      = out_found_r;

  `PCT_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(ENTITY_LIMIT), "live count above table size")
  `PCT_ASSERT(a_accept_look, clk, rst_n, accept |=> (state_r == S_LOOK), "transfer not followed by lookup")
  `PCT_ASSERT(a_insert_count, clk, rst_n, do_insert |=> (count_r == $past(count_r) + CW'(1)), "insert did not grow the table")
  `PCT_ASSERT(a_value_only_get, clk, rst_n, (out_valid_r && (out_value_r != '0)) |-> (out_found_r && (out_status_r == ST_OK)), "value returned without a hit")
  `PCT_ASSERT(a_found_status, clk, rst_n, (out_valid_r && out_found_r) |-> ((out_status_r == ST_OK) || (out_status_r == ST_PRESENT)), "hit reported with a miss status")

endmodule
